// ===== sv/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the (16,8) double-correcting block decoder:
// parity-check rows, column syndromes, status codes and stage payloads.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int WORD_W = 16;
	localparam int SYN_W  = 8;
	localparam int DATA_W = 8;
	localparam int POS_W  = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SYN_W-1:0]  syn_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]  pos_t;

	typedef enum logic [1:0] {
		ST_CLEAN  = 2'd0,
		ST_SINGLE = 2'd1,
		ST_DOUBLE = 2'd2,
		ST_UNCORR = 2'd3
	} status_t;

	// Rows of the parity-check matrix. Bit 15 of each row is position 0, as
	// in the received word, so a row masks the word directly.
	localparam word_t H_ROW [SYN_W] = '{
		16'hE780, 16'h7B40, 16'h9520, 16'hE910,
		16'h5608, 16'hAA04, 16'hCC02, 16'hF001
	};

	// Syndrome pattern of column c, row 0 as the most significant bit.
	function automatic syn_t col_syn(input int c);
		syn_t s;
		s = '0;
		for (int r = 0; r < SYN_W; r++) begin
			s[SYN_W-1-r] = H_ROW[r][WORD_W-1-c];
		end
		return s;
	endfunction

	typedef struct packed {
		word_t word;
		syn_t  syn;
	} s1_t;

	typedef struct packed {
		word_t                       word;
		syn_t                        syn;
		logic [WORD_W-1:0]           single_hit;
		logic [WORD_W-2:0]           pair_hit;
		logic [WORD_W-2:0][POS_W-1:0] pair_j;
	} s2_t;

	typedef struct packed {
		word_t   word;
		syn_t    syn;
		status_t status;
		pos_t    p1;
		pos_t    p2;
	} s3_t;

	typedef struct packed {
		data_t   data_byte;
		status_t status;
		pos_t    first_position;
		pos_t    second_position;
		syn_t    syndrome;
	} result_t;

endpackage

// ===== sv/bcd_if.sv =====
// ----------------------------------------------------------------------------
// bcd_if
// Valid/ready channels of the decoder: received words in, results out.
// ----------------------------------------------------------------------------
interface bcd_in_if import bcd_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t codeword;

	modport source (output valid, output codeword, input ready);
	modport sink (input valid, input codeword, output ready);
endinterface

interface bcd_out_if import bcd_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t data_byte;
	logic [1:0] status;
	pos_t  first_position;
	pos_t  second_position;
	syn_t  syndrome;

	modport source (output valid, output data_byte, output status,
		output first_position, output second_position, output syndrome,
		input ready);
	modport sink (input valid, input data_byte, input status,
		input first_position, input second_position, input syndrome,
		output ready);
endinterface

// ===== sv/bcd_syndrome.sv =====
// ----------------------------------------------------------------------------
// bcd_syndrome
// Stage 1: parity of the received word under each row of the check matrix.
// ----------------------------------------------------------------------------
module bcd_syndrome import bcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t codeword,
	output logic  out_valid,
	input  logic  out_ready,
	output s1_t   out_data
);

	logic valid_s1;
	s1_t  data_s1;
	syn_t syn_c;

	always_comb begin
		for (int r = 0; r < SYN_W; r++) begin
			syn_c[SYN_W-1-r] = ^(codeword & H_ROW[r]);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s1.word <= codeword;
			data_s1.syn  <= syn_c;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== sv/bcd_pair_search.sv =====
// ----------------------------------------------------------------------------
// bcd_pair_search
// Stage 2: matches the syndrome against every single column and, for each
// first column i, finds the lowest partner j > i whose pair sum matches.
// ----------------------------------------------------------------------------
module bcd_pair_search import bcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  s1_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output s2_t  out_data
);

	logic valid_s2;
	s2_t  data_s2;
	s2_t  next_c;

	always_comb begin
		next_c.word       = in_data.word;
		next_c.syn        = in_data.syn;
		next_c.single_hit = '0;
		next_c.pair_hit   = '0;
		next_c.pair_j     = '0;
		for (int c = 0; c < WORD_W; c++) begin
			next_c.single_hit[c] = (col_syn(c) == in_data.syn);
		end
		// One lane per first column; scanning j downward leaves the lowest match.
		for (int i = 0; i < WORD_W - 1; i++) begin
			for (int j = WORD_W - 1; j > i; j--) begin
				if ((col_syn(i) ^ col_syn(j)) == in_data.syn) begin
					next_c.pair_hit[i] = 1'b1;
					next_c.pair_j[i]   = POS_W'(j);
				end
			end
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s2 <= next_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== sv/bcd_select.sv =====
// ----------------------------------------------------------------------------
// bcd_select
// Stage 3: priority choice between clean, single, double and uncorrectable,
// and the positions to flip.
// ----------------------------------------------------------------------------
module bcd_select import bcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  s2_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output s3_t  out_data
);

	logic valid_s3;
	s3_t  data_s3;
	s3_t  next_c;
	logic single_any;
	logic pair_any;
	pos_t single_pos;
	pos_t pair_i;

	always_comb begin
		single_pos = '0;
		pair_i     = '0;
		for (int c = WORD_W - 1; c >= 0; c--) begin
			if (in_data.single_hit[c]) begin
				single_pos = POS_W'(c);
			end
		end
		for (int i = WORD_W - 2; i >= 0; i--) begin
			if (in_data.pair_hit[i]) begin
				pair_i = POS_W'(i);
			end
		end
		single_any = |in_data.single_hit;
		pair_any   = |in_data.pair_hit;

		next_c.word   = in_data.word;
		next_c.syn    = in_data.syn;
		next_c.status = ST_CLEAN;
		next_c.p1     = '0;
		next_c.p2     = '0;
		if (in_data.syn != '0) begin
			if (single_any) begin
				next_c.status = ST_SINGLE;
				next_c.p1     = single_pos;
			end else if (pair_any) begin
				next_c.status = ST_DOUBLE;
				next_c.p1     = pair_i;
				next_c.p2     = in_data.pair_j[pair_i];
			end else begin
				next_c.status = ST_UNCORR;
			end
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s3 <= next_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ===== sv/bcd_correct.sv =====
// ----------------------------------------------------------------------------
// bcd_correct
// Stage 4: flips the chosen positions and registers the result item.
// ----------------------------------------------------------------------------
module bcd_correct import bcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  s3_t     in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid_s4;
	result_t data_s4;
	word_t   flip_mask;
	word_t   fixed_word;

	always_comb begin
		flip_mask = '0;
		case (in_data.status)
			ST_SINGLE: begin
				flip_mask[WORD_W-1-int'(in_data.p1)] = 1'b1;
			end
			ST_DOUBLE: begin
				flip_mask[WORD_W-1-int'(in_data.p1)] = 1'b1;
				flip_mask[WORD_W-1-int'(in_data.p2)] = 1'b1;
			end
			default: begin
				flip_mask = '0;
			end
		endcase
		fixed_word = in_data.word ^ flip_mask;
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s4.data_byte       <= fixed_word[WORD_W-1 -: DATA_W];
			data_s4.status          <= in_data.status;
			data_s4.first_position  <= in_data.p1;
			data_s4.second_position <= in_data.p2;
			data_s4.syndrome        <= in_data.syn;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// ===== sv/block_code_16_8_double_correct_decoder_top.sv =====
// ----------------------------------------------------------------------------
// block_code_16_8_double_correct_decoder_top
// A word passes the syndrome, pair-search, select and correct registers.
// Throughput: one word per cycle; each of the four register stages stalls
// only when it is full and the stage after it cannot take its word.
// Reset clears the stage valid bits only; the decoder holds no other state.
// ----------------------------------------------------------------------------
module block_code_16_8_double_correct_decoder_top import bcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bcd_in_if.sink    rx,
	bcd_out_if.source res
);

	logic    v1, v2, v3;
	logic    r1, r2, r3, r4;
	s1_t     d1;
	s2_t     d2;
	s3_t     d3;
	result_t d4;

	bcd_syndrome u_syndrome (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (r1),
		.codeword  (rx.codeword),
		.out_valid (v1),
		.out_ready (r2),
		.out_data  (d1)
	);

	bcd_pair_search u_pair_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r3),
		.out_data  (d2)
	);

	bcd_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3),
		.in_data   (d2),
		.out_valid (v3),
		.out_ready (r4),
		.out_data  (d3)
	);

	bcd_correct u_correct (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r4),
		.in_data   (d3),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (d4)
	);

	assign rx.ready            = r1;
	assign res.data_byte       = d4.data_byte;
	assign res.status          = d4.status;
	assign res.first_position  = d4.first_position;
	assign res.second_position = d4.second_position;
	assign res.syndrome        = d4.syndrome;

endmodule

// ===== sim/block_code_16_8_double_correct_decoder_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_code_16_8_double_correct_decoder_top_test
// Drives received 16-bit words into the decoder and checks every result
// against its table entry or a local syndrome decoder: first a table of
// hand-picked words, then mostly encoded bytes with zero to three flipped
// bits, plus raw random words. Both sides idle at random, and there is one
// long receiver hold-off and one sender pause.
// ----------------------------------------------------------------------------
module block_code_16_8_double_correct_decoder_top_test;
	import bcd_pkg::*;

	localparam int RANDOM_ITEMS   = 1400;
	localparam int IDLE_PCT       = 30;
	localparam int BURST_FIRST    = 600;
	localparam int BURST_LAST     = 899;
	localparam int HOLD_AT_RESULT = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int PAUSE_AT_ITEM  = 1000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 200000;

	// Parity-check rows, column 0 in bit 15, so a row masks the word directly.
	localparam word_t CHECK_ROWS [SYN_W] = '{
		16'hE780, 16'h7B40, 16'h9520, 16'hE910,
		16'h5608, 16'hAA04, 16'hCC02, 16'hF001
	};

	typedef struct packed {
		word_t   codeword;
		logic    known;
		result_t outcome;
	} vector_t;

	// Rows marked known carry their result; the others go through the decoder
	// model below.
	localparam int N_VECTORS = 18;
	localparam vector_t VECTORS [N_VECTORS] = '{
		'{16'h0000, 1'b1, '{8'h00, ST_CLEAN,  4'd0,  4'd0,  8'h00}},
		'{16'hFF10, 1'b1, '{8'hFF, ST_CLEAN,  4'd0,  4'd0,  8'h00}},
		'{16'h8000, 1'b1, '{8'h00, ST_SINGLE, 4'd0,  4'd0,  8'hB7}},
		'{16'h0100, 1'b1, '{8'h00, ST_SINGLE, 4'd7,  4'd0,  8'hF0}},
		'{16'h0080, 1'b1, '{8'h00, ST_SINGLE, 4'd8,  4'd0,  8'h80}},
		'{16'h0001, 1'b1, '{8'h00, ST_SINGLE, 4'd15, 4'd0,  8'h01}},
		'{16'h7F10, 1'b1, '{8'hFF, ST_SINGLE, 4'd0,  4'd0,  8'hB7}},
		'{16'hFF11, 1'b1, '{8'hFF, ST_SINGLE, 4'd15, 4'd0,  8'h01}},
		'{16'h0003, 1'b1, '{8'h00, ST_DOUBLE, 4'd14, 4'd15, 8'h03}},
		'{16'h00FF, 1'b1, '{8'h00, ST_UNCORR, 4'd0,  4'd0,  8'hFF}},
		'{16'hFFFF, 1'b0, '0},
		'{16'hC000, 1'b0, '0},
		'{16'h8001, 1'b0, '0},
		'{16'hE000, 1'b0, '0},
		'{16'hAAAA, 1'b0, '0},
		'{16'h5555, 1'b0, '0},
		'{16'h1234, 1'b0, '0},
		'{16'h3C7E, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	bcd_in_if  rx_if ();
	bcd_out_if res_if ();

	block_code_16_8_double_correct_decoder_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	result_t decodes_due [$];
	int      mismatches    = 0;
	int      results_seen  = 0;
	int      hold_left     = 0;
	int      cycle_count   = 0;
	int      sender_idle   = IDLE_PCT;

	function automatic syn_t parity_checks(word_t w);
		syn_t s;
		for (int r = 0; r < SYN_W; r++) begin
			s[SYN_W-1-r] = ^(w & CHECK_ROWS[r]);
		end
		return s;
	endfunction

	// A column's syndrome is the syndrome of a word with only that bit set.
	function automatic syn_t column_pattern(int c);
		return parity_checks(word_t'(1) << (WORD_W-1-c));
	endfunction

	function automatic result_t decode_word(word_t w);
		result_t r;
		syn_t    s;
		word_t   repaired;
		logic    found;
		s = parity_checks(w);
		repaired = w;
		found = 1'b0;
		r.status = ST_CLEAN;
		r.first_position = '0;
		r.second_position = '0;
		if (s != '0) begin
			for (int c = 0; c < WORD_W && !found; c++) begin
				if (column_pattern(c) == s) begin
					repaired[WORD_W-1-c] = ~repaired[WORD_W-1-c];
					r.status = ST_SINGLE;
					r.first_position = pos_t'(c);
					found = 1'b1;
				end
			end
			for (int i = 0; i < WORD_W-1 && !found; i++) begin
				for (int j = i+1; j < WORD_W && !found; j++) begin
					if ((column_pattern(i) ^ column_pattern(j)) == s) begin
						repaired[WORD_W-1-i] = ~repaired[WORD_W-1-i];
						repaired[WORD_W-1-j] = ~repaired[WORD_W-1-j];
						r.status = ST_DOUBLE;
						r.first_position = pos_t'(i);
						r.second_position = pos_t'(j);
						found = 1'b1;
					end
				end
			end
			if (!found) begin
				r.status = ST_UNCORR;
			end
		end
		r.data_byte = repaired[WORD_W-1 -: DATA_W];
		r.syndrome = s;
		return r;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic offer_word(word_t w, logic known, result_t typed);
		while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.codeword <= w;
		do @(posedge clk); while (!rx_if.ready);
		decodes_due.push_back(known ? typed : decode_word(w));
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("block_code_16_8_double_correct_decoder_top_test failed");
			$finish;
		end
	end

	// Result checking and receiver ready in one process, so the hold-off is
	// counted on the same edges as the results.
	always @(posedge clk) begin : receiver
		result_t want;
		int      idle_pct;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (decodes_due.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
			end else begin
				want = decodes_due.pop_front();
				compare_field("data_byte", want.data_byte, res_if.data_byte);
				compare_field("status", want.status, res_if.status);
				compare_field("first_position", want.first_position,
					res_if.first_position);
				compare_field("second_position", want.second_position,
					res_if.second_position);
				compare_field("syndrome", want.syndrome, res_if.syndrome);
			end
			results_seen++;
			if (results_seen == HOLD_AT_RESULT) begin
				hold_left = HOLD_CYCLES;
			end
		end
		idle_pct = (results_seen >= BURST_FIRST && results_seen <= BURST_LAST) ?
			0 : IDLE_PCT;
		if (hold_left != 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= arst_n && ($urandom_range(99) >= idle_pct);
		end
	end

	initial begin : stimulus
		word_t w;
		data_t d;
		int    flips;
		rx_if.valid = 1'b0;
		rx_if.codeword = '0;
		do @(posedge clk); while (!arst_n);

		for (int n = 0; n < N_VECTORS; n++) begin
			offer_word(VECTORS[n].codeword, VECTORS[n].known, VECTORS[n].outcome);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_idle = (n >= BURST_FIRST && n <= BURST_LAST) ? 0 : IDLE_PCT;
			if (n == PAUSE_AT_ITEM) begin
				rx_if.valid <= 1'b0;
				do @(posedge clk); while (decodes_due.size() != 0);
			end
			// Mostly valid codewords with a few flipped bits, so that single,
			// double and uncorrectable paths are all reached often.
			if ($urandom_range(99) < 75) begin
				d = data_t'($urandom);
				w = {d, parity_checks({d, 8'h00})};
				flips = $urandom_range(3);
				repeat (flips) begin
					w[$urandom_range(WORD_W-1)] ^= 1'b1;
				end
			end else begin
				w = word_t'($urandom);
			end
			offer_word(w, 1'b0, '0);
		end

		rx_if.valid <= 1'b0;
		while (decodes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("block_code_16_8_double_correct_decoder_top_test passed");
		end else begin
			$display("block_code_16_8_double_correct_decoder_top_test failed");
		end
		$finish;
	end

endmodule
